// File: hdl/plt_pkg.sv
// Shared types and fixed widths for the peer learning table.
// No dependencies; the interfaces, the top level and the bench import this package.
`timescale 1ns / 1ps

package plt_pkg;

   localparam int IP_W       = 32;
   localparam int PORT_W     = 16;
   localparam int FID_W      = 29;
   localparam int AGE_W      = 8;
   localparam int SLOT_OUT_W = 4;
   localparam int STATUS_W   = 2;

   localparam logic [AGE_W-1:0] AGE_MAX       = {AGE_W{1'b1}};
   localparam logic [AGE_W-1:0] TIMEOUT_RESET = AGE_W'(10);

   localparam logic REQ_PACKET = 1'b0;
   localparam logic REQ_TICK   = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_FORWARD   = 2'd0,
      STATUS_KEEPALIVE = 2'd1,
      STATUS_FULL      = 2'd2,
      STATUS_NO_PEER   = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_AGE,
      S_LOOKUP,
      S_COMMIT,
      S_SINGLE,
      S_FANOUT
   } state_type;

endpackage

// File: hdl/plt_req_if.sv
// Request channel: packet or tick beats into the peer table.
// Depends on plt_pkg for field widths.
`timescale 1ns / 1ps

interface plt_req_if import plt_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              req_type;
   logic [IP_W-1:0]   src_ip;
   logic [PORT_W-1:0] src_port;
   logic [FID_W-1:0]  frame_id;

   modport source (output valid, req_type, src_ip, src_port, frame_id, input ready);
   modport sink   (input valid, req_type, src_ip, src_port, frame_id, output ready);
endinterface

// File: hdl/plt_rsp_if.sv
// Response channel: forward and status beats out of the peer table.
// Depends on plt_pkg for field widths.
`timescale 1ns / 1ps

interface plt_rsp_if import plt_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [STATUS_W-1:0]   status;
   logic [SLOT_OUT_W-1:0] dest_slot;
   logic [IP_W-1:0]       dest_ip;
   logic [PORT_W-1:0]     dest_port;
   logic [FID_W-1:0]      out_frame_id;
   logic [SLOT_OUT_W-1:0] sender_slot;
   logic                  last;

   modport source (output valid, status, dest_slot, dest_ip, dest_port, out_frame_id,
                   sender_slot, last, input ready);
   modport sink   (input valid, status, dest_slot, dest_ip, dest_port, out_frame_id,
                   sender_slot, last, output ready);
endinterface

// File: hdl/plt_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module plt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // hold the last read word while rd_en is low
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/peer_learning_table_fanout.sv
// Top level of the peer learning table: lookup, learning, aging and fan-out.
// Depends on plt_pkg, plt_req_if, plt_rsp_if and plt_ram.
//
//   Channel   Dir   Handshake            Carries
//   req_ch    in    valid/ready          req_type, src_ip, src_port, frame_id
//   rsp_ch    out   valid/ready          status, dest_*, out_frame_id, sender_slot, last
//   csr_*     in    csr_we, no wait      timeout_ticks
//
// One item at a time. A tick sweeps the age RAM, one slot a cycle.
// A packet scans the entry RAM for its sender, stopping early on a hit, then commits.
// For a live frame with other peers it then walks the entry RAM once more, one slot a
// cycle while the output takes beats, for the fan-out; otherwise it sends one status beat.
// Output stalls hold the walk. Reset is synchronous and clears the valid marks at once,
// so there is no clearing pass. A new item is taken while the final beat still waits.
`timescale 1ns / 1ps

module peer_learning_table_fanout
   import plt_pkg::*;
#(
   parameter int NUM_SLOTS = 16
) (
   input  logic             clock,
   input  logic             reset,
   plt_req_if.sink          req_ch,
   plt_rsp_if.source        rsp_ch,
   input  logic             csr_we,
   input  logic [AGE_W-1:0] csr_wdata
);

   localparam int SLOT_W  = $clog2(NUM_SLOTS);
   localparam int CNT_W   = $clog2(NUM_SLOTS + 1);
   localparam int ENTRY_W = IP_W + PORT_W;
   localparam logic [CNT_W-1:0] CNT_END = CNT_W'(NUM_SLOTS);

   state_type state_ff, state_in;

   logic [AGE_W-1:0]     timeout_ff;
   logic [NUM_SLOTS-1:0] valid_ff, valid_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 stage_ff, stage_in;
   logic [SLOT_W-1:0]    idx_ff, idx_in;
   logic                 found_ff, found_in;
   logic [SLOT_W-1:0]    me_ff, me_in;
   logic                 free_found_ff, free_found_in;
   logic [SLOT_W-1:0]    free_ff, free_in;
   status_type           single_ff, single_in;

   logic [IP_W-1:0]      ip_ff;
   logic [PORT_W-1:0]    port_ff;
   logic [FID_W-1:0]     fid_ff;

   logic                  rsp_valid_ff;
   status_type            rsp_status_ff;
   logic [SLOT_OUT_W-1:0] rsp_dest_slot_ff;
   logic [IP_W-1:0]       rsp_dest_ip_ff;
   logic [PORT_W-1:0]     rsp_dest_port_ff;
   logic [FID_W-1:0]      rsp_fid_ff;
   logic [SLOT_OUT_W-1:0] rsp_sender_ff;
   logic                  rsp_last_ff;

   // RAM ports
   logic               age_we, age_re;
   logic [SLOT_W-1:0]  age_waddr;
   logic [AGE_W-1:0]   age_wdata, age_rdata;
   logic               ent_we, ent_re;
   logic [SLOT_W-1:0]  ent_waddr;
   logic [ENTRY_W-1:0] ent_wdata, ent_rdata;
   logic [SLOT_W-1:0]  rd_idx;

   // datapath helpers
   logic               accept, out_free, issue, scan_done;
   logic               hit, is_dest, consume, more_dest, any_other;
   logic [SLOT_W-1:0]  me_sel;
   logic [AGE_W-1:0]   age_inc;
   logic               expire;
   logic [NUM_SLOTS-1:0] me_oh, sel_oh, above;

   logic               emit;
   status_type         emit_status;
   logic [SLOT_OUT_W-1:0] emit_dest_slot, emit_sender;
   logic [IP_W-1:0]    emit_ip;
   logic [PORT_W-1:0]  emit_port;
   logic [FID_W-1:0]   emit_fid;
   logic               emit_last;

   plt_ram #(.WIDTH(AGE_W), .DEPTH(NUM_SLOTS)) u_age_ram (
      .clock   (clock),
      .wr_en   (age_we),
      .wr_addr (age_waddr),
      .wr_data (age_wdata),
      .rd_en   (age_re),
      .rd_addr (rd_idx),
      .rd_data (age_rdata)
   );

   plt_ram #(.WIDTH(ENTRY_W), .DEPTH(NUM_SLOTS)) u_entry_ram (
      .clock   (clock),
      .wr_en   (ent_we),
      .wr_addr (ent_waddr),
      .wr_data (ent_wdata),
      .rd_en   (ent_re),
      .rd_addr (rd_idx),
      .rd_data (ent_rdata)
   );

   assign rd_idx    = cnt_ff[SLOT_W-1:0];
   assign accept    = req_ch.valid && req_ch.ready;
   assign out_free  = !rsp_valid_ff || rsp_ch.ready;
   assign scan_done = (cnt_ff == CNT_END);
   assign me_sel    = found_ff ? me_ff : free_ff;

   always_comb begin
      for (int k = 0; k < NUM_SLOTS; k++) begin
         me_oh[k]  = (SLOT_W'(k) == me_ff);
         sel_oh[k] = (SLOT_W'(k) == me_sel);
         above[k]  = (CNT_W'(k) > CNT_W'(idx_ff));
      end
   end

   assign hit       = stage_ff && valid_ff[idx_ff] && (ent_rdata == {ip_ff, port_ff});
   assign is_dest   = valid_ff[idx_ff] && (idx_ff != me_ff);
   assign more_dest = |(valid_ff & ~me_oh & above);
   assign any_other = |(valid_ff & ~sel_oh);
   assign consume   = stage_ff && (!is_dest || out_free);
   assign age_inc   = (age_rdata == AGE_MAX) ? AGE_MAX : age_rdata + AGE_W'(1);
   assign expire    = age_inc > timeout_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = (req_ch.req_type == REQ_TICK) ? S_AGE : S_LOOKUP;
            end
         end
         S_AGE: begin
            if (scan_done) state_in = S_IDLE;
         end
         S_LOOKUP: begin
            if (hit || scan_done) state_in = S_COMMIT;
         end
         S_COMMIT: begin
            if (!found_ff && !free_found_ff) state_in = S_SINGLE;
            else if (fid_ff == '0)           state_in = S_SINGLE;
            else if (!any_other)             state_in = S_SINGLE;
            else                             state_in = S_FANOUT;
         end
         S_SINGLE: begin
            if (out_free) state_in = S_IDLE;
         end
         S_FANOUT: begin
            if (scan_done && (!stage_ff || consume)) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // datapath control
   always_comb begin
      req_ch.ready   = (state_ff == S_IDLE);
      issue          = 1'b0;
      cnt_in         = '0;
      stage_in       = 1'b0;
      idx_in         = idx_ff;
      found_in       = found_ff;
      me_in          = me_ff;
      free_found_in  = free_found_ff;
      free_in        = free_ff;
      single_in      = single_ff;
      valid_in       = valid_ff;
      age_re         = 1'b0;
      age_we         = 1'b0;
      age_waddr      = idx_ff;
      age_wdata      = '0;
      ent_re         = 1'b0;
      ent_we         = 1'b0;
      ent_waddr      = free_ff;
      ent_wdata      = {ip_ff, port_ff};
      emit           = 1'b0;
      emit_status    = single_ff;
      emit_dest_slot = '0;
      emit_ip        = '0;
      emit_port      = '0;
      emit_fid       = '0;
      emit_sender    = SLOT_OUT_W'({{SLOT_OUT_W{1'b0}}, me_ff});
      emit_last      = 1'b1;

      unique case (state_ff)
         S_IDLE: begin
            found_in      = 1'b0;
            free_found_in = 1'b0;
         end
         S_AGE: begin
            issue    = !scan_done;
            age_re   = issue;
            stage_in = issue;
            idx_in   = issue ? rd_idx : idx_ff;
            cnt_in   = issue ? cnt_ff + CNT_W'(1) : cnt_ff;
            if (stage_ff && valid_ff[idx_ff]) begin
               age_we    = 1'b1;
               age_wdata = expire ? '0 : age_inc;
               if (expire) valid_in[idx_ff] = 1'b0;
            end
         end
         S_LOOKUP: begin
            issue    = !scan_done && !hit;
            ent_re   = issue;
            stage_in = issue;
            idx_in   = issue ? rd_idx : idx_ff;
            cnt_in   = issue ? cnt_ff + CNT_W'(1) : cnt_ff;
            if (hit) begin
               found_in = 1'b1;
               me_in    = idx_ff;
            end
            if (stage_ff && !valid_ff[idx_ff] && !free_found_ff) begin
               free_found_in = 1'b1;
               free_in       = idx_ff;
            end
         end
         S_COMMIT: begin
            if (!found_ff && !free_found_ff) begin
               single_in = STATUS_FULL;
               me_in     = '0;
            end else begin
               me_in            = me_sel;
               valid_in[me_sel] = 1'b1;
               ent_we           = !found_ff;
               age_we           = 1'b1;
               age_waddr        = me_sel;
               single_in        = (fid_ff == '0) ? STATUS_KEEPALIVE : STATUS_NO_PEER;
            end
         end
         S_SINGLE: begin
            emit = out_free;
         end
         S_FANOUT: begin
            issue          = !scan_done && (!stage_ff || consume);
            ent_re         = issue;
            stage_in       = issue || (stage_ff && !consume);
            idx_in         = issue ? rd_idx : idx_ff;
            cnt_in         = issue ? cnt_ff + CNT_W'(1) : cnt_ff;
            emit           = stage_ff && is_dest && out_free;
            emit_status    = STATUS_FORWARD;
            emit_dest_slot = SLOT_OUT_W'({{SLOT_OUT_W{1'b0}}, idx_ff});
            emit_ip        = ent_rdata[ENTRY_W-1:PORT_W];
            emit_port      = ent_rdata[PORT_W-1:0];
            emit_fid       = fid_ff;
            emit_last      = !more_dest;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         timeout_ff    <= TIMEOUT_RESET;
         valid_ff      <= '0;
         cnt_ff        <= '0;
         stage_ff      <= 1'b0;
         found_ff      <= 1'b0;
         free_found_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         valid_ff      <= valid_in;
         cnt_ff        <= cnt_in;
         stage_ff      <= stage_in;
         found_ff      <= found_in;
         free_found_ff <= free_found_in;
         if (csr_we) timeout_ff <= csr_wdata;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      me_ff     <= me_in;
      free_ff   <= free_in;
      single_ff <= single_in;
      if (accept) begin
         ip_ff   <= req_ch.src_ip;
         port_ff <= req_ch.src_port;
         fid_ff  <= req_ch.frame_id;
      end
      if (emit) begin
         rsp_status_ff    <= emit_status;
         rsp_dest_slot_ff <= emit_dest_slot;
         rsp_dest_ip_ff   <= emit_ip;
         rsp_dest_port_ff <= emit_port;
         rsp_fid_ff       <= emit_fid;
         rsp_sender_ff    <= emit_sender;
         rsp_last_ff      <= emit_last;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.status       = rsp_status_ff;
   assign rsp_ch.dest_slot    = rsp_dest_slot_ff;
   assign rsp_ch.dest_ip      = rsp_dest_ip_ff;
   assign rsp_ch.dest_port    = rsp_dest_port_ff;
   assign rsp_ch.out_frame_id = rsp_fid_ff;
   assign rsp_ch.sender_slot  = rsp_sender_ff;
   assign rsp_ch.last         = rsp_last_ff;

endmodule

// File: sim/peer_learning_table_fanout_tb.sv
// Self-checking bench for peer_learning_table_fanout: directed and random packet/tick beats,
// with a queue-fed driver, a scoreboarding monitor and a table predictor.
// Depends on plt_pkg, plt_req_if, plt_rsp_if and the top level with its RAMs.
`timescale 1ns / 1ps

module peer_learning_table_fanout_tb;
   import plt_pkg::*;

   localparam int NUM_SLOTS     = 16;
   localparam int POOL_SIZE     = 24;
   localparam int SETTLE_CYCLES = 2 * NUM_SLOTS + 8;
   localparam int CYCLE_LIMIT   = 600000;
   localparam logic [FID_W-1:0] FID_MAX = {FID_W{1'b1}};

   typedef struct packed {
      logic              req_type;
      logic [IP_W-1:0]   src_ip;
      logic [PORT_W-1:0] src_port;
      logic [FID_W-1:0]  frame_id;
   } peer_req_type;

   typedef struct packed {
      status_type            status;
      logic [SLOT_OUT_W-1:0] dest_slot;
      logic [IP_W-1:0]       dest_ip;
      logic [PORT_W-1:0]     dest_port;
      logic [FID_W-1:0]      out_frame_id;
      logic [SLOT_OUT_W-1:0] sender_slot;
      logic                  last;
   } peer_rsp_type;

   logic             clock = 1'b0;
   logic             reset;
   logic             csr_we;
   logic [AGE_W-1:0] csr_wdata;

   plt_req_if req_ch ();
   plt_rsp_if rsp_ch ();

   peer_learning_table_fanout #(.NUM_SLOTS(NUM_SLOTS)) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always #4 clock = ~clock;

   // predicted peer table
   logic             tbl_valid [NUM_SLOTS];
   logic [IP_W-1:0]  tbl_ip    [NUM_SLOTS];
   logic [PORT_W-1:0] tbl_port [NUM_SLOTS];
   logic [AGE_W-1:0] tbl_age   [NUM_SLOTS];
   logic [AGE_W-1:0] timeout_q;

   peer_req_type pending_beats [$];
   peer_rsp_type fanout_expect [$];

   logic [IP_W-1:0]   pool_ip   [POOL_SIZE];
   logic [PORT_W-1:0] pool_port [POOL_SIZE];

   peer_req_type cur_req;
   int        send_gap;
   int        take_gap;
   bit        drain_hold;
   bit        in_flight;
   bit        calm;

   int errors;
   int mismatches;
   int cycles;
   int packets_seen, ticks_seen, beats_seen;
   int n_forward, n_keepalive, n_full, n_lone;

   function automatic peer_rsp_type make_rsp(status_type st, int dslot, logic [IP_W-1:0] dip,
                                             logic [PORT_W-1:0] dport, logic [FID_W-1:0] fid,
                                             int sslot, logic lst);
      peer_rsp_type r;
      r.status       = st;
      r.dest_slot    = SLOT_OUT_W'(dslot);
      r.dest_ip      = dip;
      r.dest_port    = dport;
      r.out_frame_id = fid;
      r.sender_slot  = SLOT_OUT_W'(sslot);
      r.last         = lst;
      return r;
   endfunction

   // Work out the beats one accepted item causes and update the table copy.
   task automatic learn_and_fanout(input peer_req_type b);
      int me;
      int others;
      int sent;
      int j;
      me = -1;
      if (b.req_type == REQ_TICK) begin
         ticks_seen++;
         for (j = 0; j < NUM_SLOTS; j++) begin
            if (tbl_valid[j]) begin
               if (tbl_age[j] != AGE_MAX) tbl_age[j]++;
               if (tbl_age[j] > timeout_q) begin
                  tbl_valid[j] = 1'b0;
                  tbl_age[j]   = '0;
               end
            end
         end
         return;
      end
      packets_seen++;
      for (j = 0; j < NUM_SLOTS && me < 0; j++)
         if (tbl_valid[j] && tbl_ip[j] == b.src_ip && tbl_port[j] == b.src_port) me = j;
      if (me < 0) begin
         for (j = 0; j < NUM_SLOTS && me < 0; j++)
            if (!tbl_valid[j]) me = j;
         if (me < 0) begin
            n_full++;
            fanout_expect.push_back(make_rsp(STATUS_FULL, 0, '0, '0, '0, 0, 1'b1));
            return;
         end
         tbl_valid[me] = 1'b1;
         tbl_ip[me]    = b.src_ip;
         tbl_port[me]  = b.src_port;
      end
      tbl_age[me] = '0;
      if (b.frame_id == '0) begin
         n_keepalive++;
         fanout_expect.push_back(make_rsp(STATUS_KEEPALIVE, 0, '0, '0, '0, me, 1'b1));
         return;
      end
      others = 0;
      for (j = 0; j < NUM_SLOTS; j++)
         if (tbl_valid[j] && j != me) others++;
      if (others == 0) begin
         n_lone++;
         fanout_expect.push_back(make_rsp(STATUS_NO_PEER, 0, '0, '0, '0, me, 1'b1));
         return;
      end
      sent = 0;
      for (j = 0; j < NUM_SLOTS; j++) begin
         if (tbl_valid[j] && j != me) begin
            sent++;
            n_forward++;
            fanout_expect.push_back(make_rsp(STATUS_FORWARD, j, tbl_ip[j], tbl_port[j],
                                             b.frame_id, me, sent == others));
         end
      end
   endtask

   // Driver: present queued beats, hold while stalled, gap after each accepted beat.
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid    <= 1'b0;
         req_ch.req_type <= REQ_PACKET;
         req_ch.src_ip   <= '0;
         req_ch.src_port <= '0;
         req_ch.frame_id <= '0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            learn_and_fanout(cur_req);
            in_flight = 1'b0;
            send_gap  = calm ? 0 : $urandom_range(0, 4);
            if ($urandom_range(0, 24) == 0) drain_hold = 1'b1;
         end
         if (req_ch.valid && !req_ch.ready) begin
            // hold the beat until taken
         end else if (send_gap > 0) begin
            send_gap--;
            req_ch.valid <= 1'b0;
         end else if (drain_hold && fanout_expect.size() != 0) begin
            req_ch.valid <= 1'b0;
         end else if (pending_beats.size() != 0) begin
            drain_hold = 1'b0;
            cur_req    = pending_beats.pop_front();
            in_flight  = 1'b1;
            req_ch.valid    <= 1'b1;
            req_ch.req_type <= cur_req.req_type;
            req_ch.src_ip   <= cur_req.src_ip;
            req_ch.src_port <= cur_req.src_port;
            req_ch.frame_id <= cur_req.frame_id;
         end else begin
            drain_hold = 1'b0;
            req_ch.valid <= 1'b0;
         end
      end
   end

   // Monitor: compare each accepted result beat with the oldest expectation.
   always @(posedge clock) begin
      peer_rsp_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            beats_seen++;
            if (fanout_expect.size() == 0) begin
               errors++;
               mismatches++;
               if (mismatches <= 10)
                  $display("tb mismatch: unexpected beat status=%0d dest=%0d sender=%0d",
                           rsp_ch.status, rsp_ch.dest_slot, rsp_ch.sender_slot);
            end else begin
               want = fanout_expect.pop_front();
               if (rsp_ch.status !== want.status || rsp_ch.dest_slot !== want.dest_slot ||
                   rsp_ch.dest_ip !== want.dest_ip || rsp_ch.dest_port !== want.dest_port ||
                   rsp_ch.out_frame_id !== want.out_frame_id ||
                   rsp_ch.sender_slot !== want.sender_slot || rsp_ch.last !== want.last) begin
                  errors++;
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("tb mismatch: exp st=%0d ds=%0d ip=%h pt=%h fid=%h ss=%0d last=%0d",
                              want.status, want.dest_slot, want.dest_ip, want.dest_port,
                              want.out_frame_id, want.sender_slot, want.last);
                     $display("             got st=%0d ds=%0d ip=%h pt=%h fid=%h ss=%0d last=%0d",
                              rsp_ch.status, rsp_ch.dest_slot, rsp_ch.dest_ip,
                              rsp_ch.dest_port, rsp_ch.out_frame_id, rsp_ch.sender_slot,
                              rsp_ch.last);
                  end
               end
            end
            take_gap = calm ? 0 : $urandom_range(0, 4);
         end else if (take_gap > 0) begin
            take_gap--;
         end
         rsp_ch.ready <= (take_gap == 0);
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb: run exceeded %0d cycles", CYCLE_LIMIT);
         $display("tb: failure");
         $finish;
      end
   end

   task automatic queue_beat(input logic kind, input logic [IP_W-1:0] ip,
                             input logic [PORT_W-1:0] port, input logic [FID_W-1:0] fid);
      peer_req_type b;
      b.req_type = kind;
      b.src_ip   = ip;
      b.src_port = port;
      b.frame_id = fid;
      pending_beats.push_back(b);
   endtask

   task automatic queue_tick();
      queue_beat(REQ_TICK, $urandom, PORT_W'($urandom), FID_W'($urandom));
   endtask

   function automatic logic [FID_W-1:0] live_fid();
      return FID_W'($urandom_range(1, FID_MAX));
   endfunction

   // Mostly known peers so lookups hit; a few strangers and ticks in between.
   task automatic queue_random(input int count);
      peer_req_type b;
      int k;
      int pick;
      repeat (count) begin
         b.req_type = REQ_PACKET;
         b.src_ip   = $urandom;
         b.src_port = PORT_W'($urandom);
         b.frame_id = live_fid();
         pick = $urandom_range(0, 99);
         if (pick < 20) begin
            b.req_type = REQ_TICK;
            b.frame_id = FID_W'($urandom);
         end else begin
            if ($urandom_range(0, 6) != 0) begin
               k = $urandom_range(0, POOL_SIZE - 1);
               b.src_ip   = pool_ip[k];
               b.src_port = pool_port[k];
            end
            pick = $urandom_range(0, 19);
            if (pick < 3) b.frame_id = '0;
            else if (pick == 3) b.frame_id = FID_MAX;
         end
         pending_beats.push_back(b);
      end
   endtask

   task automatic wait_idle();
      @(posedge clock);
      while (pending_beats.size() != 0 || in_flight || fanout_expect.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_timeout(input logic [AGE_W-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      timeout_q = value;
   endtask

   initial begin
      int k;
      reset        <= 1'b1;
      csr_we       <= 1'b0;
      csr_wdata    <= '0;
      for (k = 0; k < NUM_SLOTS; k++) begin
         tbl_valid[k] = 1'b0;
         tbl_ip[k]    = '0;
         tbl_port[k]  = '0;
         tbl_age[k]   = '0;
      end
      timeout_q = TIMEOUT_RESET;
      // corner addresses first, then near neighbours, then random peers
      pool_ip[0] = '0;            pool_port[0] = '0;
      pool_ip[1] = '1;            pool_port[1] = '1;
      pool_ip[2] = '0;            pool_port[2] = '1;
      pool_ip[3] = '1;            pool_port[3] = '0;
      pool_ip[4] = 32'h0A000001;  pool_port[4] = 16'd5000;
      pool_ip[5] = 32'h0A000001;  pool_port[5] = 16'd5001;
      pool_ip[6] = 32'h0A000002;  pool_port[6] = 16'd5000;
      for (k = 7; k < POOL_SIZE; k++) begin
         pool_ip[k]   = $urandom;
         pool_port[k] = PORT_W'($urandom);
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: empty tick, lone peer, keepalive, fill the table, refuse, full fan-out
      queue_tick();
      queue_beat(REQ_PACKET, pool_ip[0], pool_port[0], FID_W'(1));
      queue_beat(REQ_PACKET, pool_ip[0], pool_port[0], '0);
      queue_beat(REQ_PACKET, pool_ip[1], pool_port[1], FID_MAX);
      queue_beat(REQ_PACKET, pool_ip[2], pool_port[2], live_fid());
      queue_beat(REQ_PACKET, pool_ip[3], pool_port[3], live_fid());
      for (k = 4; k < NUM_SLOTS; k++)
         queue_beat(REQ_PACKET, pool_ip[k], pool_port[k], live_fid());
      queue_beat(REQ_PACKET, pool_ip[NUM_SLOTS], pool_port[NUM_SLOTS], live_fid());
      queue_beat(REQ_PACKET, pool_ip[0], pool_port[0], FID_MAX);
      queue_tick();
      wait_idle();

      // zero timeout: one tick frees every slot
      write_timeout(8'd0);
      queue_tick();
      queue_beat(REQ_PACKET, pool_ip[5], pool_port[5], live_fid());
      queue_beat(REQ_PACKET, pool_ip[6], pool_port[6], live_fid());
      queue_tick();
      wait_idle();

      write_timeout(8'd3);
      queue_random(100);
      wait_idle();

      // timeout of six: a slot idle for six ticks stays, the seventh frees it
      calm = 1'b1;
      write_timeout(8'd6);
      queue_beat(REQ_PACKET, pool_ip[1], pool_port[1], live_fid());
      queue_beat(REQ_PACKET, pool_ip[2], pool_port[2], '0);
      repeat (6) queue_tick();
      queue_beat(REQ_PACKET, pool_ip[2], pool_port[2], live_fid());
      queue_tick();
      queue_beat(REQ_PACKET, pool_ip[2], pool_port[2], live_fid());
      wait_idle();

      // all-ones timeout: nothing expires
      calm = 1'b0;
      write_timeout(8'd255);
      queue_beat(REQ_PACKET, pool_ip[1], pool_port[1], live_fid());
      repeat (12) queue_tick();
      queue_beat(REQ_PACKET, pool_ip[1], pool_port[1], live_fid());
      wait_idle();

      write_timeout(AGE_W'($urandom_range(1, 20)));
      calm = 1'b1;
      queue_random(55);
      wait_idle();
      calm = 1'b0;
      queue_random(55);
      wait_idle();

      $display("tb: %0d packets and %0d ticks, %0d result beats checked", packets_seen,
               ticks_seen, beats_seen);
      $display("tb: %0d forward, %0d keepalive, %0d table full, %0d no peer, %0d mismatches",
               n_forward, n_keepalive, n_full, n_lone, mismatches);
      if (errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
